[rtl/assert_macros.svh]
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk.
`define CHK_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising edge of clk.
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ptpn_pkg.sv]
// Constants, sequencer states and helper functions of the pilot tone PLL.
package ptpn_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int SAMPLE_WIDTH  = 16;
	localparam int MAX_STAGES    = 24;
	localparam int NSTG = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

	// CORDIC datapath width: sample x Q1.15 x 2^16 plus growth and sign
	localparam int CW    = SAMPLE_WIDTH + 34;
	localparam int AW    = 64;
	localparam int MPW   = 25;
	localparam int CNT_W = 5;

	localparam logic [17:0] GAIN_CP  = 18'd174719;
	localparam logic [17:0] GAIN_CI  = 18'd232980;
	localparam logic [29:0] CORDIC_K = 30'd652032874;

	// configuration register indexes
	localparam logic [1:0] REG_PHASE_STEP     = 2'd0;
	localparam logic [1:0] REG_NORM_BANDWIDTH = 2'd1;
	localparam logic [1:0] REG_NCO_SCALE      = 2'd2;
	localparam logic [1:0] REG_PHASE_ADJUST   = 2'd3;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_MUL_I,
		SQ_MUL_Q,
		SQ_VEC,
		SQ_MUL_KP,
		SQ_MUL_BW2,
		SQ_MUL_KI,
		SQ_MUL_IE,
		SQ_MUL_PE,
		SQ_ROT_FB,
		SQ_FB_WR,
		SQ_MUL_NCO,
		SQ_ROT_OUT,
		SQ_FIN
	} seq_t;

	// atan(2^-i) in 2^-32 turns
	function automatic logic [31:0] atan_turn(input logic [CNT_W-1:0] i);
		logic [31:0] r;
		begin
			case (i)
				5'd0:    r = 32'd536870912;
				5'd1:    r = 32'd316933406;
				5'd2:    r = 32'd167458907;
				5'd3:    r = 32'd85004756;
				5'd4:    r = 32'd42667331;
				5'd5:    r = 32'd21354465;
				5'd6:    r = 32'd10679838;
				5'd7:    r = 32'd5340245;
				5'd8:    r = 32'd2670163;
				5'd9:    r = 32'd1335087;
				5'd10:   r = 32'd667544;
				5'd11:   r = 32'd333772;
				5'd12:   r = 32'd166886;
				5'd13:   r = 32'd83443;
				5'd14:   r = 32'd41722;
				5'd15:   r = 32'd20861;
				5'd16:   r = 32'd10430;
				5'd17:   r = 32'd5215;
				5'd18:   r = 32'd2608;
				5'd19:   r = 32'd1304;
				5'd20:   r = 32'd652;
				5'd21:   r = 32'd326;
				5'd22:   r = 32'd163;
				5'd23:   r = 32'd81;
				default: r = 32'd0;
			endcase
			return r;
		end
	endfunction

	// round half up from 2^30 scale to Q1.15 and saturate
	function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] x);
		logic signed [CW-1:0] half;
		logic signed [CW-1:0] mx;
		logic signed [CW-1:0] mn;
		logic signed [CW-1:0] r;
		logic signed [15:0]   o;
		begin
			half = CW'(16384);
			mx   = CW'(32767);
			mn   = -mx - CW'(1);
			r    = (x + half) >>> 15;
			if (r > mx)
				o = 16'sh7fff;
			else if (r < mn)
				o = 16'sh8000;
			else
				o = r[15:0];
			return o;
		end
	endfunction

endpackage

[rtl/pilot_tone_pll_nco_unit.sv]
// Pilot tone PLL: phase detector, PI loop filter and CORDIC NCO on a shared serial datapath.
//
// Input channel: sample with in_valid / in_stall; a word is taken when in_valid is high and
// in_stall low. Output channel: nco_out and phase_error with out_valid / out_stall, one
// result word for every sample word.
// Config port: cfg_we, cfg_index, cfg_data; write only while no sample is in flight.
// All multiplies run on one shift-and-add unit, one multiplier bit per cycle; the
// vectoring and both rotation CORDIC passes run on one shared stage, one iteration a cycle.
// The time from one accept to the next is set by the serial multiplier and the iterative
// CORDIC; out_valid rises when the result is loaded in the final step.
// in_stall is high from accept until the result is loaded into the output register.
// A result waiting in the output register does not block the next sample; a new result
// only waits in the final step while the previous word is still stalled.
// Reset clears the loop state, sets feedback cosine to full scale and loads the register
// defaults (phase step 0, bandwidth 655, scale 4096, adjust 0).
module pilot_tone_pll_nco_unit
	import ptpn_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [15:0]             nco_out,
	output logic signed [15:0]             phase_error
);

	seq_t seq_q, seq_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	logic [31:0]        phase_step_q;
	logic [15:0]        norm_bandwidth_q;
	logic [15:0]        nco_scale_q;
	logic signed [15:0] phase_adjust_q;

	logic signed [AW-1:0]  acc_q, acc_d, mc_q, mc_d;
	logic signed [MPW-1:0] mp_q, mp_d;
	logic signed [CW-1:0]  cx_q, cx_d, cy_q, cy_d;
	logic signed [33:0]    cz_q, cz_d;
	logic                  neg_q, neg_d, zero_q, zero_d;

	logic signed [SAMPLE_WIDTH-1:0] samp_q, samp_d;
	logic signed [15:0] fcos_q, fcos_d, fsin_q, fsin_d, err_q, err_d;
	logic [31:0] integ_q, integ_d, est_q, est_d, ref_q, ref_d, np_q, np_d;
	logic [33:0] kp_q, kp_d;
	logic [34:0] ki_q, ki_d;

	logic               out_valid_q, out_valid_d;
	logic signed [15:0] nco_out_q, nco_out_d, phase_error_q, phase_error_d;

	// shift-and-add multiplier
	logic                  is_mul, first, last;
	logic [CNT_W-1:0]      nbits;
	logic signed [AW-1:0]  src_mc, mc_e, acc_e, addend, prod;
	logic signed [MPW-1:0] src_mp, mp_e;

	// shared CORDIC stage
	logic [31:0]          arg, rot_p;
	logic signed [33:0]   rz0, rz_i, lim, halfturn, ze, z_vec, z_rot, at;
	logic                 rneg_i, nege, zero_e;
	logic signed [CW-1:0] xe, ye, dx, dy, x_vec, y_vec, x_rot, y_rot, xf, yf;

	assign arg = ref_q + est_q;
	assign lim = 34'sd1073741824;
	assign halfturn = 34'sd2147483648;

	always_comb begin
		is_mul = 1'b1;
		nbits  = CNT_W'(NSTG);
		src_mc = '0;
		src_mp = '0;
		case (seq_q)
			SQ_MUL_I: begin
				nbits  = CNT_W'(SAMPLE_WIDTH);
				src_mc = {{(AW-16){fcos_q[15]}}, fcos_q};
				src_mp = {{(MPW-SAMPLE_WIDTH){samp_q[SAMPLE_WIDTH-1]}}, samp_q};
			end
			SQ_MUL_Q: begin
				nbits  = CNT_W'(SAMPLE_WIDTH);
				src_mc = {{(AW-16){fsin_q[15]}}, fsin_q};
				src_mp = {{(MPW-SAMPLE_WIDTH){samp_q[SAMPLE_WIDTH-1]}}, samp_q};
			end
			SQ_MUL_KP: begin
				nbits  = CNT_W'(17);
				src_mc = {{(AW-18){1'b0}}, GAIN_CP};
				src_mp = {{(MPW-16){1'b0}}, norm_bandwidth_q};
			end
			SQ_MUL_BW2: begin
				nbits  = CNT_W'(17);
				src_mc = {{(AW-16){1'b0}}, norm_bandwidth_q};
				src_mp = {{(MPW-16){1'b0}}, norm_bandwidth_q};
			end
			SQ_MUL_KI: begin
				nbits  = CNT_W'(19);
				src_mc = {{(AW-35){1'b0}}, ki_q};
				src_mp = {{(MPW-18){1'b0}}, GAIN_CI};
			end
			SQ_MUL_IE: begin
				nbits  = CNT_W'(16);
				src_mc = {{(AW-35){1'b0}}, ki_q};
				src_mp = {{(MPW-16){err_q[15]}}, err_q};
			end
			SQ_MUL_PE: begin
				nbits  = CNT_W'(16);
				src_mc = {{(AW-34){1'b0}}, kp_q};
				src_mp = {{(MPW-16){err_q[15]}}, err_q};
			end
			SQ_MUL_NCO: begin
				nbits  = CNT_W'(17);
				src_mc = {{(AW-32){1'b0}}, arg};
				src_mp = {{(MPW-16){1'b0}}, nco_scale_q};
			end
			default: is_mul = 1'b0;
		endcase
	end

	assign first  = (cnt_q == '0);
	assign last   = (cnt_q == nbits - CNT_W'(1));
	assign mc_e   = first ? src_mc : mc_q;
	assign mp_e   = first ? src_mp : mp_q;
	assign acc_e  = first ? '0 : acc_q;
	// the multiplier's top bit carries negative weight
	assign addend = mp_e[0] ? (last ? -mc_e : mc_e) : '0;
	assign prod   = acc_e + addend;

	// CORDIC entry values: fold the phase into the right half plane
	assign rot_p = (seq_q == SQ_ROT_FB) ? arg : np_q;
	always_comb begin
		rz0    = {{2{rot_p[31]}}, rot_p};
		rz_i   = rz0;
		rneg_i = 1'b0;
		if (rz0 >= lim) begin
			rz_i   = rz0 - halfturn;
			rneg_i = 1'b1;
		end else if (rz0 < -lim) begin
			rz_i   = rz0 + halfturn;
			rneg_i = 1'b1;
		end
	end

	always_comb begin
		xe     = cx_q;
		ye     = cy_q;
		ze     = cz_q;
		nege   = neg_q;
		zero_e = zero_q;
		if (first) begin
			if (seq_q == SQ_VEC) begin
				zero_e = (cx_q == '0) && (cy_q == '0);
				nege   = 1'b0;
				if (cx_q[CW-1]) begin
					xe = -cx_q;
					ye = -cy_q;
					ze = 34'sh080000000;
				end else begin
					ze = '0;
				end
			end else begin
				xe   = {{(CW-30){1'b0}}, CORDIC_K};
				ye   = '0;
				ze   = rz_i;
				nege = rneg_i;
			end
		end
	end

	assign dx = ye >>> cnt_q;
	assign dy = xe >>> cnt_q;
	assign at = {2'b00, atan_turn(cnt_q)};

	always_comb begin
		if (!ye[CW-1] && (ye != '0)) begin
			x_vec = xe + dx;
			y_vec = ye - dy;
			z_vec = ze + at;
		end else begin
			x_vec = xe - dx;
			y_vec = ye + dy;
			z_vec = ze - at;
		end
		if (!ze[33]) begin
			x_rot = xe - dx;
			y_rot = ye + dy;
			z_rot = ze - at;
		end else begin
			x_rot = xe + dx;
			y_rot = ye - dy;
			z_rot = ze + at;
		end
	end

	assign xf = neg_q ? -cx_q : cx_q;
	assign yf = neg_q ? -cy_q : cy_q;

	always_comb begin
		seq_d   = seq_q;
		cnt_d   = cnt_q;
		acc_d   = acc_q;
		mc_d    = mc_q;
		mp_d    = mp_q;
		cx_d    = cx_q;
		cy_d    = cy_q;
		cz_d    = cz_q;
		neg_d   = neg_q;
		zero_d  = zero_q;
		samp_d  = samp_q;
		fcos_d  = fcos_q;
		fsin_d  = fsin_q;
		err_d   = err_q;
		integ_d = integ_q;
		est_d   = est_q;
		ref_d   = ref_q;
		np_d    = np_q;
		kp_d    = kp_q;
		ki_d    = ki_q;
		nco_out_d     = nco_out_q;
		phase_error_d = phase_error_q;
		out_valid_d   = out_valid_q && out_stall;
		in_stall      = (seq_q != SQ_IDLE);

		if (is_mul) begin
			acc_d = prod;
			mc_d  = mc_e <<< 1;
			mp_d  = mp_e >>> 1;
			cnt_d = last ? '0 : cnt_q + CNT_W'(1);
		end

		case (seq_q)
			SQ_IDLE: begin
				if (in_valid) begin
					samp_d = sample;
					cnt_d  = '0;
					seq_d  = SQ_MUL_I;
				end
			end
			SQ_MUL_I: begin
				if (last) begin
					cy_d  = {prod[CW-17:0], 16'h0000};
					seq_d = SQ_MUL_Q;
				end
			end
			SQ_MUL_Q: begin
				if (last) begin
					cx_d  = {prod[CW-17:0], 16'h0000};
					seq_d = SQ_VEC;
				end
			end
			SQ_VEC: begin
				cx_d   = x_vec;
				cy_d   = y_vec;
				cz_d   = z_vec;
				neg_d  = nege;
				zero_d = zero_e;
				cnt_d  = last ? '0 : cnt_q + CNT_W'(1);
				if (last) begin
					err_d = zero_e ? 16'sh0000 : z_vec[31:16];
					seq_d = SQ_MUL_KP;
				end
			end
			SQ_MUL_KP: begin
				if (last) begin
					kp_d  = prod[33:0];
					seq_d = SQ_MUL_BW2;
				end
			end
			SQ_MUL_BW2: begin
				if (last) begin
					ki_d  = prod[34:0];
					seq_d = SQ_MUL_KI;
				end
			end
			SQ_MUL_KI: begin
				if (last) begin
					ki_d  = prod[50:16];
					seq_d = SQ_MUL_IE;
				end
			end
			SQ_MUL_IE: begin
				if (last) begin
					integ_d = integ_q + prod[47:16];
					seq_d   = SQ_MUL_PE;
				end
			end
			SQ_MUL_PE: begin
				if (last) begin
					est_d = est_q + prod[47:16] + integ_q;
					ref_d = ref_q + phase_step_q;
					seq_d = SQ_ROT_FB;
				end
			end
			SQ_ROT_FB, SQ_ROT_OUT: begin
				cx_d  = x_rot;
				cy_d  = y_rot;
				cz_d  = z_rot;
				neg_d = nege;
				cnt_d = last ? '0 : cnt_q + CNT_W'(1);
				if (last)
					seq_d = (seq_q == SQ_ROT_FB) ? SQ_FB_WR : SQ_FIN;
			end
			SQ_FB_WR: begin
				fcos_d = to_q15(xf);
				fsin_d = to_q15(yf);
				seq_d  = SQ_MUL_NCO;
			end
			SQ_MUL_NCO: begin
				if (last) begin
					np_d  = prod[43:12] + {phase_adjust_q, 16'h0000};
					seq_d = SQ_ROT_OUT;
				end
			end
			SQ_FIN: begin
				if (!(out_valid_q && out_stall)) begin
					nco_out_d     = to_q15(xf);
					phase_error_d = err_q;
					out_valid_d   = 1'b1;
					seq_d         = SQ_IDLE;
				end
			end
			default: seq_d = SQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SQ_IDLE;
		end else begin
			seq_q <= seq_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q            <= '0;
			out_valid_q      <= 1'b0;
			phase_step_q     <= '0;
			norm_bandwidth_q <= 16'd655;
			nco_scale_q      <= 16'd4096;
			phase_adjust_q   <= '0;
			integ_q          <= '0;
			est_q            <= '0;
			ref_q            <= '0;
			fcos_q           <= 16'sh7fff;
			fsin_q           <= '0;
		end else begin
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
			integ_q     <= integ_d;
			est_q       <= est_d;
			ref_q       <= ref_d;
			fcos_q      <= fcos_d;
			fsin_q      <= fsin_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_PHASE_STEP:     phase_step_q     <= cfg_data;
					REG_NORM_BANDWIDTH: norm_bandwidth_q <= cfg_data[15:0];
					REG_NCO_SCALE:      nco_scale_q      <= cfg_data[15:0];
					REG_PHASE_ADJUST:   phase_adjust_q   <= cfg_data[15:0];
					default:            phase_step_q     <= phase_step_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		acc_q         <= acc_d;
		mc_q          <= mc_d;
		mp_q          <= mp_d;
		cx_q          <= cx_d;
		cy_q          <= cy_d;
		cz_q          <= cz_d;
		neg_q         <= neg_d;
		zero_q        <= zero_d;
		samp_q        <= samp_d;
		err_q         <= err_d;
		np_q          <= np_d;
		kp_q          <= kp_d;
		ki_q          <= ki_d;
		nco_out_q     <= nco_out_d;
		phase_error_q <= phase_error_d;
	end

	assign out_valid   = out_valid_q;
	assign nco_out     = nco_out_q;
	assign phase_error = phase_error_q;

`include "assert_macros.svh"

	`CHK_NEXT(a_accept_starts, in_valid && !in_stall, seq_q == SQ_MUL_I, "accepted word did not start the multiply")
	`CHK_IMPL(a_cordic_count, seq_q == SQ_VEC || seq_q == SQ_ROT_FB || seq_q == SQ_ROT_OUT, cnt_q < CNT_W'(NSTG), "CORDIC iteration count out of range")
	`CHK_NEXT(a_fin_loads, seq_q == SQ_FIN && !(out_valid && out_stall), out_valid && seq_q == SQ_IDLE, "result not loaded at end of item")

endmodule
